[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the draw engine.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/lcg_pkg.sv]
// Types, codes and constants of the LCG draw engine.
// No dependencies; imported by every module of the block.
package lcg_pkg;

  localparam int SEED_W    = 31;
  localparam int VALUE_W   = 32;
  localparam int THR_W     = 32;
  localparam int Q_FRAC    = 31;

  localparam logic [31:0]       LCG_MUL = 32'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD = 31'd12345;
  localparam logic [THR_W-1:0]  Q31_ONE = 32'h8000_0000;

  localparam int MAX_COUNT = 255;
  localparam int COUNT_W   = $clog2(MAX_COUNT + 1);

  // Serial multiplier geometry: multiplier operand consumed one digit a cycle
  localparam int DIGIT_W   = 4;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int N_DIGITS  = MUL_B_W / DIGIT_W;
  localparam int DCNT_W    = $clog2(N_DIGITS);
  localparam int ACC_HI_W  = MUL_A_W + DIGIT_W + 1;
  localparam int ACC_W     = ACC_HI_W + MUL_B_W;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RAW     = 2'd1,
    OP_RANGE   = 2'd2,
    OP_POISSON = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SATURATED = 2'd1,
    ST_RANGE_ERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_RANGE,
    S_PROD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage

[hw/rtl/lcg_smul.sv]
// Digit-serial unsigned multiplier, one 4-bit digit of b per cycle.
// Depends on lcg_pkg for widths and the request/response structs.
module lcg_smul (
  input  logic              clk,
  input  logic              rst,
  input  lcg_pkg::mul_req_t req,
  output lcg_pkg::mul_rsp_t rsp
);
  import lcg_pkg::*;

  logic [MUL_A_W-1:0]         a_reg;
  logic [ACC_W-1:0]           acc;
  logic [DCNT_W-1:0]          dcnt;
  logic                       busy;
  logic                       done;
  logic [DIGIT_W-1:0]         digit;
  logic [MUL_A_W+DIGIT_W-1:0] partial;
  logic [ACC_HI_W-1:0]        acc_sum;
  logic [ACC_W-1:0]           acc_next;

  // One partial product per cycle, added to the upper half, then shift right a digit
  assign digit    = acc[DIGIT_W-1:0];
  assign partial  = {DIGIT_W'(0), a_reg} * {MUL_A_W'(0), digit};
  assign acc_sum  = acc[ACC_W-1:MUL_B_W] + ACC_HI_W'(partial);
  assign acc_next = {DIGIT_W'(0), acc_sum, acc[MUL_B_W-1:DIGIT_W]};

  // Control: busy for one cycle per digit, done pulses after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      dcnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        dcnt <= '0;
      end else if (busy) begin
        dcnt <= dcnt + DCNT_W'(1);
        if (dcnt == DCNT_W'(N_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      acc   <= {ACC_HI_W'(0), req.b};
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc[MUL_P_W-1:0];

endmodule

[hw/rtl/lcg_random_draw_engine.sv]
// Top level of the LCG draw engine: sequencer, seed, threshold and result beat.
// Depends on lcg_pkg, lcg_smul and assert_macros.svh.
//
//   channel  direction  handshake           payload
//   in       in         in_valid/in_ready   operation, seed_value, range_low, range_high
//   out      out        out_valid/out_ready value, status
//   cfg      in         cfg_we              cfg_wdata (Poisson threshold, Q1.31)
//
// Every multiply runs on one shared serial unit.
// Per beat: load needs no multiply, raw draw one, range draw two (one when high is below
// low), Poisson draw two per step (none when the threshold is 1.0 or above).
// Reset clears the seed to zero and sets the threshold to 1.0; no clearing pass.
// in_ready is high only while no beat is in work; a finished result waits in
// the output register, so the next beat is taken while out_ready is low.
`include "assert_macros.svh"

module lcg_random_draw_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcg_pkg::op_t        operation,
  input  logic [30:0]         seed_value,
  input  logic signed [31:0]  range_low,
  input  logic signed [31:0]  range_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  value,
  output lcg_pkg::status_t    status,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import lcg_pkg::*;

  state_t                   state;
  state_t                   state_next;
  op_t                      op_r;
  logic [SEED_W-1:0]        seed;
  logic [THR_W-1:0]         threshold;
  logic signed [VALUE_W-1:0] range_low_r;
  logic signed [VALUE_W-1:0] range_high_r;
  logic [THR_W-1:0]         prod;
  logic [COUNT_W-1:0]       count;
  logic [VALUE_W-1:0]       res_value;
  status_t                  res_status;

  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  logic [SEED_W-1:0]        seed_adv;
  logic [MUL_A_W-1:0]       span;
  logic                     hi_below_lo;
  logic [THR_W-1:0]         prod_new;
  logic                     prod_le_thr;
  logic [COUNT_W-1:0]       count_inc;
  logic                     count_sat;
  logic                     out_free;
  logic                     in_fire;

  lcg_smul u_smul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Datapath terms taken from the multiplier result and the held bounds
  assign seed_adv    = mul_rsp.product[SEED_W-1:0] + LCG_ADD;
  assign span        = MUL_A_W'({range_high_r[VALUE_W-1], range_high_r}
                                - {range_low_r[VALUE_W-1], range_low_r})
                       + MUL_A_W'(1);
  assign hi_below_lo = range_high_r < range_low_r;
  assign prod_new    = mul_rsp.product[Q_FRAC+THR_W-1:Q_FRAC];
  assign prod_le_thr = prod_new <= threshold;
  assign count_inc   = count + COUNT_W'(1);
  assign count_sat   = count_inc >= COUNT_W'(MAX_COUNT);
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;

  // Sequencer: next state and multiplier requests
  always_comb begin
    state_next = state;
    mul_req    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (operation)
            OP_LOAD: state_next = S_FINISH;
            OP_RAW, OP_RANGE: begin
              mul_req.start = 1'b1;
              mul_req.a     = MUL_A_W'(seed);
              mul_req.b     = LCG_MUL;
              state_next    = S_SEED;
            end
            OP_POISSON: begin
              if (threshold >= Q31_ONE) begin
                state_next = S_FINISH;
              end else begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(seed);
                mul_req.b     = LCG_MUL;
                state_next    = S_SEED;
              end
            end
          endcase
        end
      end
      S_SEED: begin
        if (mul_rsp.done) begin
          unique case (op_r)
            OP_RANGE: begin
              if (hi_below_lo) begin
                state_next = S_FINISH;
              end else begin
                mul_req.start = 1'b1;
                mul_req.a     = span;
                mul_req.b     = MUL_B_W'(seed_adv);
                state_next    = S_RANGE;
              end
            end
            OP_POISSON: begin
              mul_req.start = 1'b1;
              mul_req.a     = MUL_A_W'(prod);
              mul_req.b     = MUL_B_W'(seed_adv);
              state_next    = S_PROD;
            end
            OP_LOAD, OP_RAW: state_next = S_FINISH;
          endcase
        end
      end
      S_RANGE: begin
        if (mul_rsp.done) begin
          state_next = S_FINISH;
        end
      end
      S_PROD: begin
        if (mul_rsp.done) begin
          if (prod_le_thr || count_sat) begin
            state_next = S_FINISH;
          end else begin
            // Draw the next uniform from the seed stored last step
            mul_req.start = 1'b1;
            mul_req.a     = MUL_A_W'(seed);
            mul_req.b     = LCG_MUL;
            state_next    = S_SEED;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state, output valid, seed and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seed      <= '0;
      threshold <= Q31_ONE;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && operation == OP_LOAD) begin
        seed <= seed_value;
      end else if (state == S_SEED && mul_rsp.done) begin
        seed <= seed_adv;
      end
    end
  end

  // Item registers and the pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= operation;
      range_low_r  <= range_low;
      range_high_r <= range_high;
      prod         <= Q31_ONE;
      count        <= '0;
      res_value    <= '0;
      res_status   <= ST_OK;
    end
    if (state == S_SEED && mul_rsp.done) begin
      if (op_r == OP_RAW) begin
        res_value <= VALUE_W'(seed_adv);
      end
      if (op_r == OP_RANGE && hi_below_lo) begin
        res_status <= ST_RANGE_ERR;
      end
    end
    if (state == S_RANGE && mul_rsp.done) begin
      res_value <= range_low_r + prod_new;
    end
    if (state == S_PROD && mul_rsp.done) begin
      prod <= prod_new;
      if (prod_le_thr) begin
        res_value <= VALUE_W'(count);
      end else begin
        count <= count_inc;
        if (count_sat) begin
          res_value  <= VALUE_W'(MAX_COUNT);
          res_status <= ST_SATURATED;
        end
      end
    end
  end

  // Output register: load the result beat once the slot is free
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  // Checks
  `ASSERT_IMP(a_done_when_waiting, clk, rst, mul_rsp.done,
              state == S_SEED || state == S_RANGE || state == S_PROD)
  `ASSERT_IMP(a_count_below_max, clk, rst, state == S_PROD,
              count < COUNT_W'(MAX_COUNT))
  `ASSERT_IMP(a_sat_value, clk, rst, out_valid && status == ST_SATURATED,
              value == VALUE_W'(MAX_COUNT))
  `ASSERT_NXT(a_finish_loads_out, clk, rst, state == S_FINISH && out_free,
              out_valid && state == S_IDLE)

endmodule
